FILE: src/s3b_pkg.sv
package s3b_pkg;

    // pixel, position, result and configuration widths
    localparam int PIX_W   = 8;
    localparam int POS_W   = 10;
    localparam int VAL_W   = 12;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // frame size after reset
    localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = 11'd1024;

    typedef logic [PIX_W-1:0] pix_t;

    // two retained window columns per row: [row][0] older, [row][1] newer
    typedef logic [2:0][1:0][PIX_W-1:0] win_t;

    // one reported pixel
    typedef struct packed {
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
        logic [VAL_W-1:0] value;
    } result_t;

endpackage

FILE: src/s3b_kernel.sv
module s3b_kernel (
    input  s3b_pkg::win_t          win,
    input  s3b_pkg::pix_t          up2,
    input  s3b_pkg::pix_t          up1,
    input  s3b_pkg::pix_t          px,
    input  logic [s3b_pkg::POS_W-1:0] column,
    input  logic [s3b_pkg::POS_W-1:0] row,
    output s3b_pkg::result_t       interior_res,
    output s3b_pkg::result_t       border_res
);

    logic [9:0]  corners;
    logic [9:0]  sides;
    logic [11:0] weighted;

    // binomial weights 1-2-1 in both directions
    always_comb
    begin
        corners = {2'b00, win[0][0]} + {2'b00, up2} + {2'b00, win[2][0]} + {2'b00, px};
        sides   = {2'b00, win[0][1]} + {2'b00, win[2][1]} + {2'b00, win[1][0]}
                + {2'b00, up1};
        weighted = {2'b00, corners} + {1'b0, sides, 1'b0} + {2'b00, win[1][1], 2'b00};
    end

    // interior result refers to the pixel one up and one left
    always_comb
    begin
        interior_res.column = column - 10'd1;
        interior_res.row    = row - 10'd1;
        interior_res.value  = weighted;
    end

    // border pixel passes through scaled to sixteenths
    always_comb
    begin
        border_res.column = column;
        border_res.row    = row;
        border_res.value  = {px, 4'b0000};
    end

endmodule

FILE: src/smooth_3x3_binomial_filter.sv
// 3x3 binomial smoothing filter for a raster-order stream of 8-bit pixels.
// Input channel: in_valid / in_ready with pixel. Output channel: out_valid /
// out_ready with out_column, out_row, smoothed (sixteenths) and last_of_run,
// which marks the final result caused by one input item.
// Configuration: cfg_write with cfg_index and cfg_data; the user must see that
// they are written only while idle, as the block does not enforce it. Index 0
// is the frame width, index 1 the frame height (both 1..1024).
// Throughput: one item per cycle while the receiver takes every result. An item
// that causes two results (the pixel one up-left is interior and the current
// pixel is border, i.e. at row ends and on the last row) holds the input back,
// as the output pair drains one result per cycle while out_ready is high.
// The line store is read as the item is taken into the middle stage; its kernel
// result enters the output pair when the item leaves that stage.
// Reset clears the counters, the window and all valid state; frame size goes
// to 1024 x 1024. Line stores are not cleared and need no clearing pass.
// When the receiver stalls, the output pair holds its results and an item with
// a result waits in the middle stage; until one does, input keeps being taken.
module smooth_3x3_binomial_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [s3b_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [s3b_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [s3b_pkg::PIX_W-1:0]         pixel,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [s3b_pkg::POS_W-1:0]         out_column,
    output logic [s3b_pkg::POS_W-1:0]         out_row,
    output logic [s3b_pkg::VAL_W-1:0]         smoothed,
    output logic                              last_of_run
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int XW0 = (CW > RW) ? CW + 1 : RW + 1;
    localparam int XW  = (XW0 > 12) ? XW0 : 12;
    localparam logic [XW-1:0] MAXW_X = XW'(MAX_WIDTH);
    localparam logic [XW-1:0] MAXH_X = XW'(MAX_HEIGHT);

    // configuration and position state
    logic [s3b_pkg::CFG_W-1:0] frame_width_reg;
    logic [s3b_pkg::CFG_W-1:0] frame_height_reg;
    logic [CW-1:0]             col_cnt_reg, col_cnt_next;
    logic [RW-1:0]             row_cnt_reg, row_cnt_next;

    // middle stage
    logic                      a_valid_reg;
    s3b_pkg::pix_t             a_px_reg;
    logic [CW-1:0]             a_idx_reg;
    logic [s3b_pkg::POS_W-1:0] a_col_reg;
    logic [s3b_pkg::POS_W-1:0] a_row_reg;
    logic                      a_int_reg;
    logic                      a_bor_reg;

    // line stores and their read path
    s3b_pkg::pix_t             older_mem [MAX_WIDTH];
    s3b_pkg::pix_t             newer_mem [MAX_WIDTH];
    s3b_pkg::pix_t             older_q_reg;
    s3b_pkg::pix_t             newer_q_reg;
    logic                      byp_reg, byp_next;
    s3b_pkg::pix_t             byp_older_reg;
    s3b_pkg::pix_t             byp_newer_reg;
    s3b_pkg::pix_t             a_up2;
    s3b_pkg::pix_t             a_up1;

    // window and output pair
    s3b_pkg::win_t             win_reg;
    logic [1:0]                b_rem_reg;
    s3b_pkg::result_t          r0_reg;
    s3b_pkg::result_t          r1_reg;
    s3b_pkg::result_t          cur_res;
    s3b_pkg::result_t          interior_res;
    s3b_pkg::result_t          border_res;

    logic                      in_acc;
    logic                      out_acc;
    logic                      a_go;
    logic                      b_free;
    logic [XW-1:0]             col_x, row_x;
    logic [XW-1:0]             cfg_w_x, cfg_h_x;
    logic [XW-1:0]             w_eff, h_eff;
    logic [XW-1:0]             wm1, hm1;
    logic                      last_col, last_row;
    logic                      interior, border;

    // effective frame size and position tests
    always_comb
    begin
        cfg_w_x = XW'(frame_width_reg);
        cfg_h_x = XW'(frame_height_reg);
        if (cfg_w_x == '0)
            w_eff = XW'(1);
        else if (cfg_w_x > MAXW_X)
            w_eff = MAXW_X;
        else
            w_eff = cfg_w_x;
        if (cfg_h_x == '0)
            h_eff = XW'(1);
        else if (cfg_h_x > MAXH_X)
            h_eff = MAXH_X;
        else
            h_eff = cfg_h_x;
        wm1      = w_eff - XW'(1);
        hm1      = h_eff - XW'(1);
        col_x    = XW'(col_cnt_reg);
        row_x    = XW'(row_cnt_reg);
        last_col = (col_x >= wm1);
        last_row = (row_x >= hm1);
        interior = (col_x >= XW'(2)) && (col_x <= wm1)
                && (row_x >= XW'(2)) && (row_x <= hm1);
        border   = (col_x == '0) || last_col || (row_x == '0) || last_row;
    end

    // handshakes and stage advance
    always_comb
    begin
        out_acc  = out_valid && out_ready;
        b_free   = (b_rem_reg == 2'd0) || ((b_rem_reg == 2'd1) && out_ready);
        a_go     = a_valid_reg && (!(a_int_reg || a_bor_reg) || b_free);
        in_ready = !a_valid_reg || a_go;
        in_acc   = in_valid && in_ready;
    end

    // next position
    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (last_col)
        begin
            col_cnt_next = '0;
            row_cnt_next = last_row ? '0 : row_cnt_reg + RW'(1);
        end
        else
        begin
            col_cnt_next = col_cnt_reg + CW'(1);
        end
    end

    // read bypass when the item in flight writes the entry being read
    always_comb
    begin
        byp_next = a_go && (a_idx_reg == col_cnt_reg);
        a_up2    = byp_reg ? byp_older_reg : older_q_reg;
        a_up1    = byp_reg ? byp_newer_reg : newer_q_reg;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= s3b_pkg::FRAME_SIZE_RESET;
            frame_height_reg <= s3b_pkg::FRAME_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                s3b_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                s3b_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            a_valid_reg <= 1'b0;
            byp_reg     <= 1'b0;
            b_rem_reg   <= 2'd0;
            win_reg     <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
                byp_reg     <= byp_next;
            end
            if (in_acc)
                a_valid_reg <= 1'b1;
            else if (a_go)
                a_valid_reg <= 1'b0;
            if (a_go)
            begin
                win_reg[0] <= {a_up2, win_reg[0][1]};
                win_reg[1] <= {a_up1, win_reg[1][1]};
                win_reg[2] <= {a_px_reg, win_reg[2][1]};
            end
            if (a_go && (a_int_reg || a_bor_reg))
                b_rem_reg <= (a_int_reg && a_bor_reg) ? 2'd2 : 2'd1;
            else if (out_acc)
                b_rem_reg <= b_rem_reg - 2'd1;
        end
    end

    // middle stage payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_px_reg      <= pixel;
            a_idx_reg     <= col_cnt_reg;
            a_col_reg     <= col_x[s3b_pkg::POS_W-1:0];
            a_row_reg     <= row_x[s3b_pkg::POS_W-1:0];
            a_int_reg     <= interior;
            a_bor_reg     <= border;
            byp_older_reg <= a_up1;
            byp_newer_reg <= a_px_reg;
        end
    end

    // line stores: write back when the item leaves, read when an item is taken
    always_ff @(posedge clk)
    begin
        if (a_go)
        begin
            older_mem[a_idx_reg] <= a_up1;
            newer_mem[a_idx_reg] <= a_px_reg;
        end
        if (in_acc)
        begin
            older_q_reg <= older_mem[col_cnt_reg];
            newer_q_reg <= newer_mem[col_cnt_reg];
        end
    end

    s3b_kernel u_kernel (
        .win          (win_reg),
        .up2          (a_up2),
        .up1          (a_up1),
        .px           (a_px_reg),
        .column       (a_col_reg),
        .row          (a_row_reg),
        .interior_res (interior_res),
        .border_res   (border_res)
    );

    // output pair: r1 holds the last result of the item, r0 the one before
    always_ff @(posedge clk)
    begin
        if (a_go && (a_int_reg || a_bor_reg))
        begin
            r0_reg <= interior_res;
            r1_reg <= a_bor_reg ? border_res : interior_res;
        end
    end

    // result presentation
    always_comb
    begin
        cur_res     = (b_rem_reg == 2'd2) ? r0_reg : r1_reg;
        out_valid   = (b_rem_reg != 2'd0);
        out_column  = cur_res.column;
        out_row     = cur_res.row;
        smoothed    = cur_res.value;
        last_of_run = (b_rem_reg == 2'd1);
    end

`ifndef ASSERT_OFF
    // a first result handed over is always followed by its last one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid && last_of_run)
        else $error("second result of an item missing");

    // input is held back only by an item waiting in the middle stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> a_valid_reg && !a_go)
        else $error("input stalled with no item waiting");

    // a waiting item keeps its pixel and position
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !a_go |=> a_valid_reg && $stable(a_px_reg) && $stable(a_idx_reg))
        else $error("middle stage lost its item");

    // results stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> smoothed <= 12'd4080)
        else $error("smoothed value out of range");
`endif

endmodule
